/* hw/rtl/s256tdw_pkg.sv */
// shared types, constants and round functions for the sha-256 tail weigher
package s256tdw_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT_RD,
        ST_EXT_WAIT,
        ST_EXT_WR,
        ST_PRE_RD,
        ST_PRE_WAIT,
        ST_PRE_RND,
        ST_TL_RD,
        ST_TL_WAIT,
        ST_TL_RND,
        ST_POP,
        ST_DONE
    } s256tdw_state_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam int SCHED_DEPTH = 57;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] hstate_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RC [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig_lo0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig_lo1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t sig_up0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t sig_up1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

/* hw/rtl/s256tdw_round.sv */
// one sha-256 round unit, combinational; the top level instantiates it once per message
module s256tdw_round (
    input  s256tdw_pkg::hstate_t v,
    input  s256tdw_pkg::word_t   k,
    input  s256tdw_pkg::word_t   w,
    output s256tdw_pkg::hstate_t q
);
    import s256tdw_pkg::*;

    word_t ch;
    word_t mj;
    word_t t1;
    word_t t2;

    always_comb
    begin
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + sig_up1(v[4]) + ch + k + w;
        t2 = sig_up0(v[0]) + mj;
        q[7] = v[6];
        q[6] = v[5];
        q[5] = v[4];
        q[4] = v[3] + t1;
        q[3] = v[2];
        q[2] = v[1];
        q[1] = v[0];
        q[0] = t1 + t2;
    end

endmodule

/* hw/rtl/sha256_tail_difference_weigher_unit.sv */
// top level: schedule memories, prefix/tail sequencer and popcount
// A load request of words 0..14 only writes the schedule memory; word 15
// also keeps busy high while the schedule memory is extended one word at a
// time (four reads and one write per word) and rounds 0..56 run through the
// first round unit instance. An evaluate request keeps busy high while each
// free-word round takes its word from a register, each derived word takes
// three schedule reads before its round, the round unit serves both messages
// at once through two instances, and the popcount merges one state word per
// cycle. done pulses for exactly one cycle with the result, in the same cycle
// that busy falls; the receiver cannot stall it.
module sha256_tail_difference_weigher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic        message_select,
    input  logic [3:0]  word_index,
    input  logic [31:0] message_word,
    input  logic [31:0] first_w57,
    input  logic [31:0] first_w58,
    input  logic [31:0] first_w59,
    input  logic [31:0] first_w60,
    input  logic [31:0] second_w57,
    input  logic [31:0] second_w58,
    input  logic [31:0] second_w59,
    input  logic [31:0] second_w60,
    output logic        done,
    output logic [8:0]  difference_weight,
    output logic        full_match
);
    import s256tdw_pkg::*;

    s256tdw_state_t state_reg, state_next;
    logic [5:0]  idx_reg, idx_next;
    logic [1:0]  ph_reg, ph_next;
    logic        sel_reg, sel_next;
    word_t       fw_reg [2][4];
    word_t       tw_reg [2][3];
    hstate_t     v_reg [2];
    hstate_t     pre_reg [2];
    word_t       acc_reg [4];
    word_t       rd_reg [2];
    logic [8:0]  wt_reg;
    logic [8:0]  res_reg;
    logic        done_reg;

    word_t   mem0 [SCHED_DEPTH];
    word_t   mem1 [SCHED_DEPTH];
    logic        we;
    logic [5:0]  waddr;
    word_t       wdata;
    logic        wsel;
    logic [5:0]  raddr;

    hstate_t rq [2];
    word_t   rw [2];
    word_t   rk;
    word_t   xr;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign difference_weight = res_reg;
    assign full_match = (res_reg == 9'd0);

    always_ff @(posedge clk)
    begin
        if (we && !wsel)
            mem0[waddr] <= wdata;
        if (we && wsel)
            mem1[waddr] <= wdata;
        rd_reg[0] <= mem0[raddr];
        rd_reg[1] <= mem1[raddr];
    end

    // extension: ph 0..3 reads i-16, i-15, i-7, i-2
    // tail: ph 0..2 reads (45,46,54) (46,47,55) (47,48,56) per word
    always_comb
    begin
        raddr = 6'd0;
        unique case (state_reg)
            ST_EXT_RD:
            begin
                unique case (ph_reg)
                    2'd0: raddr = idx_reg - 6'd16;
                    2'd1: raddr = idx_reg - 6'd15;
                    2'd2: raddr = idx_reg - 6'd7;
                    default: raddr = idx_reg - 6'd2;
                endcase
            end
            ST_PRE_RD, ST_PRE_WAIT: raddr = idx_reg;
            ST_TL_RD:
            begin
                unique case (ph_reg)
                    2'd0: raddr = idx_reg - 6'd16;
                    2'd1: raddr = idx_reg - 6'd15;
                    default: raddr = idx_reg - 6'd7;
                endcase
            end
            default: raddr = 6'd0;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        waddr = idx_reg;
        wdata = acc_reg[0] + acc_reg[1] + acc_reg[2] + sig_lo1(acc_reg[3]);
        wsel = sel_reg;
        if (state_reg == ST_IDLE && start && command == CMD_LOAD)
        begin
            we = 1'b1;
            waddr = {2'b00, word_index};
            wdata = message_word;
            wsel = message_select;
        end
        else if (state_reg == ST_EXT_WR)
            we = 1'b1;
    end

    assign rk = RC[idx_reg];

    always_comb
    begin
        if (state_reg == ST_TL_RND)
        begin
            for (int m = 0; m < 2; m++)
            begin
                if (idx_reg < 6'd61)
                    rw[m] = fw_reg[m][idx_reg[1:0] - 2'd1];
                else
                    rw[m] = tw_reg[m][idx_reg[1:0] - 2'd1];
            end
        end
        else
        begin
            rw[0] = rd_reg[0];
            rw[1] = rd_reg[1];
            if (sel_reg)
                rw[0] = rd_reg[1];
        end
    end

    s256tdw_round u_rnd0 (.v(v_reg[0]), .k(rk), .w(rw[0]), .q(rq[0]));
    s256tdw_round u_rnd1 (.v(v_reg[1]), .k(rk), .w(rw[1]), .q(rq[1]));

    assign xr = v_reg[0][idx_reg[2:0]] ^ v_reg[1][idx_reg[2:0]];

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        ph_next = ph_reg;
        sel_next = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_EVAL)
                    begin
                        state_next = ST_TL_RD;
                        idx_next = 6'd57;
                        ph_next = 2'd0;
                    end
                    else if (word_index == 4'd15)
                    begin
                        state_next = ST_EXT_RD;
                        idx_next = 6'd16;
                        ph_next = 2'd0;
                        sel_next = message_select;
                    end
                end
            end
            ST_EXT_RD: state_next = ST_EXT_WAIT;
            ST_EXT_WAIT:
            begin
                ph_next = ph_reg + 2'd1;
                state_next = (ph_reg == 2'd3) ? ST_EXT_WR : ST_EXT_RD;
            end
            ST_EXT_WR:
            begin
                if (idx_reg == 6'd56)
                begin
                    idx_next = 6'd0;
                    state_next = ST_PRE_RD;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                    state_next = ST_EXT_RD;
                end
            end
            ST_PRE_RD: state_next = ST_PRE_WAIT;
            ST_PRE_WAIT: state_next = ST_PRE_RND;
            ST_PRE_RND:
            begin
                if (idx_reg == 6'd56)
                    state_next = ST_IDLE;
                else
                begin
                    idx_next = idx_reg + 6'd1;
                    state_next = ST_PRE_RD;
                end
            end
            ST_TL_RD:
            begin
                if (idx_reg < 6'd61)
                    state_next = ST_TL_RND;
                else
                    state_next = ST_TL_WAIT;
            end
            ST_TL_WAIT:
            begin
                if (ph_reg == 2'd2)
                begin
                    ph_next = 2'd0;
                    state_next = ST_TL_RND;
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                    state_next = ST_TL_RD;
                end
            end
            ST_TL_RND:
            begin
                if (idx_reg == 6'd63)
                begin
                    idx_next = 6'd0;
                    state_next = ST_POP;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                    state_next = ST_TL_RD;
                end
            end
            ST_POP:
            begin
                idx_next = idx_reg + 6'd1;
                if (idx_reg == 6'd7)
                    state_next = ST_DONE;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            ph_reg <= '0;
            sel_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            ph_reg <= ph_next;
            sel_reg <= sel_next;
            done_reg <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && command == CMD_EVAL)
        begin
            fw_reg[0][0] <= first_w57;
            fw_reg[0][1] <= first_w58;
            fw_reg[0][2] <= first_w59;
            fw_reg[0][3] <= first_w60;
            fw_reg[1][0] <= second_w57;
            fw_reg[1][1] <= second_w58;
            fw_reg[1][2] <= second_w59;
            fw_reg[1][3] <= second_w60;
            v_reg[0] <= pre_reg[0];
            v_reg[1] <= pre_reg[1];
            wt_reg <= '0;
        end
        if (state_reg == ST_EXT_WAIT)
        begin
            acc_reg[ph_reg] <= ph_reg == 2'd1 ? sig_lo0(sel_reg ? rd_reg[1] : rd_reg[0])
                                              : (sel_reg ? rd_reg[1] : rd_reg[0]);
        end
        if (state_reg == ST_EXT_WR && idx_reg == 6'd56)
        begin
            for (int j = 0; j < 8; j++)
                v_reg[0][j] <= IV[j];
        end
        if (state_reg == ST_PRE_RND)
        begin
            v_reg[0] <= rq[0];
            if (idx_reg == 6'd56)
                pre_reg[sel_reg] <= rq[0];
        end
        if (state_reg == ST_TL_WAIT)
        begin
            for (int m = 0; m < 2; m++)
            begin
                unique case (ph_reg)
                    2'd0: acc_reg[2*m] <= rd_reg[m];
                    2'd1: acc_reg[2*m] <= acc_reg[2*m] + sig_lo0(rd_reg[m]);
                    default: acc_reg[2*m] <= acc_reg[2*m] + rd_reg[m];
                endcase
            end
            if (ph_reg == 2'd2)
            begin
                tw_reg[0][idx_reg[1:0] - 2'd1] <= acc_reg[0] + rd_reg[0]
                    + sig_lo1(idx_reg == 6'd61 ? fw_reg[0][2] :
                              idx_reg == 6'd62 ? fw_reg[0][3] : tw_reg[0][0]);
                tw_reg[1][idx_reg[1:0] - 2'd1] <= acc_reg[2] + rd_reg[1]
                    + sig_lo1(idx_reg == 6'd61 ? fw_reg[1][2] :
                              idx_reg == 6'd62 ? fw_reg[1][3] : tw_reg[1][0]);
            end
        end
        if (state_reg == ST_TL_RND)
        begin
            v_reg[0] <= rq[0];
            v_reg[1] <= rq[1];
        end
        if (state_reg == ST_POP)
            wt_reg <= wt_reg + 9'($countones(xr));
        if (state_reg == ST_DONE)
            res_reg <= wt_reg;
    end

    a_busy_on_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_EVAL) |=> busy)
        else $error("evaluate request did not raise busy");
    a_done_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DONE))
        else $error("done without finishing popcount");
    a_no_done_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXT_RD || state_reg == ST_PRE_RND) |-> !done)
        else $error("result during prefix build");

endmodule

/* tb/sv/sha256_tail_difference_weigher_unit_tb.sv */
// testbench for the sha-256 tail difference weigher: scoreboard against a local round model
`timescale 1ns / 1ps
module sha256_tail_difference_weigher_unit_tb;
    import s256tdw_pkg::*;

    typedef struct {
        logic        command;
        logic        message_select;
        logic [3:0]  word_index;
        logic [31:0] message_word;
        logic [31:0] free_first [4];
        logic [31:0] free_second [4];
    } request_t;

    typedef struct {
        logic [8:0] weight;
        logic       match;
    } weight_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        command = CMD_LOAD;
    logic        message_select = 1'b0;
    logic [3:0]  word_index = '0;
    logic [31:0] message_word = '0;
    logic [31:0] first_w57 = '0, first_w58 = '0, first_w59 = '0, first_w60 = '0;
    logic [31:0] second_w57 = '0, second_w58 = '0, second_w59 = '0, second_w60 = '0;
    logic        done;
    logic [8:0]  difference_weight;
    logic        full_match;

    logic [31:0] msg_sched [2][57];
    logic [31:0] msg_prefix [2][8];
    request_t    pending_requests [$];
    weight_t     expected_weights [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;
    bit          hold_sender = 1'b0;
    bit          stimulus_done = 1'b0;

    sha256_tail_difference_weigher_unit u_dut (.*);

    always #5 clk = ~clk;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction
    function automatic logic [31:0] small_s0(logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction
    function automatic logic [31:0] small_s1(logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic void sha_round(ref logic [31:0] v [8], input logic [31:0] k, w);
        logic [31:0] ch, mj, t1, t2;
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch + k + w;
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + mj;
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    endfunction

    function automatic void tail_state(int m, logic [31:0] fw [4], ref logic [31:0] v [8]);
        logic [31:0] w [7];
        for (int i = 0; i < 4; i++) w[i] = fw[i];
        w[4] = small_s1(w[2]) + msg_sched[m][54] + small_s0(msg_sched[m][46]) + msg_sched[m][45];
        w[5] = small_s1(w[3]) + msg_sched[m][55] + small_s0(msg_sched[m][47]) + msg_sched[m][46];
        w[6] = small_s1(w[4]) + msg_sched[m][56] + small_s0(msg_sched[m][48]) + msg_sched[m][47];
        for (int i = 0; i < 8; i++) v[i] = msg_prefix[m][i];
        for (int i = 0; i < 7; i++) sha_round(v, ROUND_K[57 + i], w[i]);
    endfunction

    function automatic void predict_weight(request_t r);
        logic [31:0] v1 [8];
        logic [31:0] v2 [8];
        weight_t     e;
        int          m, cnt;
        if (r.command == CMD_LOAD) begin
            m = r.message_select;
            msg_sched[m][r.word_index] = r.message_word;
            if (r.word_index == 4'd15) begin
                for (int i = 16; i < 57; i++)
                    msg_sched[m][i] = small_s1(msg_sched[m][i-2]) + msg_sched[m][i-7]
                        + small_s0(msg_sched[m][i-15]) + msg_sched[m][i-16];
                for (int i = 0; i < 8; i++) v1[i] = START_HASH[i];
                for (int i = 0; i < 57; i++) sha_round(v1, ROUND_K[i], msg_sched[m][i]);
                for (int i = 0; i < 8; i++) msg_prefix[m][i] = v1[i];
            end
        end else begin
            tail_state(0, r.free_first, v1);
            tail_state(1, r.free_second, v2);
            cnt = 0;
            for (int i = 0; i < 8; i++) cnt += $countones(v1[i] ^ v2[i]);
            e.weight = cnt[8:0];
            e.match = (cnt == 0);
            expected_weights.push_back(e);
        end
    endfunction

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return 32'h0;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t make_load(logic sel, logic [3:0] idx, logic [31:0] w);
        request_t r;
        r.command = CMD_LOAD; r.message_select = sel; r.word_index = idx; r.message_word = w;
        for (int i = 0; i < 4; i++) begin
            r.free_first[i] = $urandom;
            r.free_second[i] = $urandom;
        end
        return r;
    endfunction

    function automatic request_t make_eval(int mode);
        request_t r;
        r.command = CMD_EVAL; r.message_select = 1'($urandom); r.word_index = 4'($urandom);
        r.message_word = $urandom;
        for (int i = 0; i < 4; i++) begin
            r.free_first[i] = rand_word(mode);
            r.free_second[i] = (mode == 3) ? r.free_first[i] : rand_word(mode);
        end
        return r;
    endfunction

    task automatic queue_block(logic sel, int mode);
        for (int i = 0; i < 16; i++)
            pending_requests.push_back(make_load(sel, 4'(i), rand_word(mode)));
    endtask

    task automatic drain_requests();
        while (pending_requests.size() != 0) @(posedge clk);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            predict_weight('{command, message_select, word_index, message_word,
                '{first_w57, first_w58, first_w59, first_w60},
                '{second_w57, second_w58, second_w59, second_w60}});
            void'(pending_requests.pop_front());
            gap_left = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
            if (gap_left == 0 && pending_requests.size() != 0 && !hold_sender) begin
                command <= pending_requests[0].command;
                message_select <= pending_requests[0].message_select;
                word_index <= pending_requests[0].word_index;
                message_word <= pending_requests[0].message_word;
                {first_w57, first_w58, first_w59, first_w60} <= {pending_requests[0].free_first[0],
                    pending_requests[0].free_first[1], pending_requests[0].free_first[2],
                    pending_requests[0].free_first[3]};
                {second_w57, second_w58, second_w59, second_w60} <= {pending_requests[0].free_second[0],
                    pending_requests[0].free_second[1], pending_requests[0].free_second[2],
                    pending_requests[0].free_second[3]};
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() != 0 && !hold_sender) begin
                start <= 1'b1;
                command <= pending_requests[0].command;
                message_select <= pending_requests[0].message_select;
                word_index <= pending_requests[0].word_index;
                message_word <= pending_requests[0].message_word;
                {first_w57, first_w58, first_w59, first_w60} <= {pending_requests[0].free_first[0],
                    pending_requests[0].free_first[1], pending_requests[0].free_first[2],
                    pending_requests[0].free_first[3]};
                {second_w57, second_w58, second_w59, second_w60} <= {pending_requests[0].free_second[0],
                    pending_requests[0].free_second[1], pending_requests[0].free_second[2],
                    pending_requests[0].free_second[3]};
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        weight_t e;
        cycle_count++;
        if (rst_n && done) begin
            if (expected_weights.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result weight=%0d match=%0b", difference_weight, full_match);
            end else begin
                e = expected_weights.pop_front();
                if (e.weight !== difference_weight || e.match !== full_match) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected weight=%0d match=%0b, got weight=%0d match=%0b",
                            e.weight, e.match, difference_weight, full_match);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sha256_tail_difference_weigher_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin
        request_t r;
        int       kind;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all-zero and all-ones blocks, identical messages, extreme free words
        queue_block(1'b0, 0);
        queue_block(1'b1, 0);
        pending_requests.push_back(make_eval(0));
        pending_requests.push_back(make_eval(1));
        pending_requests.push_back(make_eval(3));
        drain_requests();
        queue_block(1'b0, 1);
        queue_block(1'b1, 1);
        pending_requests.push_back(make_eval(1));
        pending_requests.push_back(make_eval(2));
        // reload of a low word only touches that entry
        pending_requests.push_back(make_load(1'b0, 4'd3, 32'h12345678));
        pending_requests.push_back(make_eval(2));
        drain_requests();

        // pause until every expected result has come
        hold_sender = 1'b1;
        while (expected_weights.size() != 0) @(posedge clk);
        hold_sender = 1'b0;

        // random: mostly evaluations, occasional reload of words or whole blocks
        for (int n = 0; n < 750; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 2) begin
                queue_block(1'($urandom_range(0, 1)), 2);
            end else if (kind < 6) begin
                pending_requests.push_back(make_load(1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 14)), $urandom));
            end else if (kind < 8) begin
                r = make_eval(3);
                pending_requests.push_back(r);
            end else begin
                pending_requests.push_back(make_eval(kind < 12 ? kind - 8 : 2));
            end
            if (pending_requests.size() > 20) drain_requests();
        end
        drain_requests();
        stimulus_done = 1'b1;
        while (expected_weights.size() != 0 || start) @(posedge clk);
        repeat (400) @(posedge clk);

        if (mismatch_count == 0 && expected_weights.size() == 0)
            $display("sha256_tail_difference_weigher_unit_tb: PASS");
        else
            $display("sha256_tail_difference_weigher_unit_tb: FAIL");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/s256tdw_pkg.sv
hw/rtl/s256tdw_round.sv
hw/rtl/sha256_tail_difference_weigher_unit.sv
tb/sv/sha256_tail_difference_weigher_unit_tb.sv
